/* sv/siot_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// siot_pkg
// Shared types, constants and helpers of the sorted interval overlap tagger.
// ----------------------------------------------------------------------------
package siot_pkg;

    localparam int TABLE_DEPTH = 4096;
    localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int POS_W       = 32;
    localparam int COUNT_W     = 32;
    localparam int ENTRY_W     = 2 * POS_W;

    localparam logic [1:0] CMD_CLEAR  = 2'd0;
    localparam logic [1:0] CMD_APPEND = 2'd1;
    localparam logic [1:0] CMD_QUERY  = 2'd2;

    typedef struct packed {
        logic [1:0]       cmd;
        logic [POS_W-1:0] start_pos;
        logic [POS_W-1:0] stop_pos;
    } req_t;

    typedef struct packed {
        logic               overlap;
        logic               dropped;
        logic [COUNT_W-1:0] tagged_count;
        logic [COUNT_W-1:0] total_count;
    } rsp_t;

    // controller -> datapath
    typedef struct packed {
        logic clear;
        logic append;
        logic load_query;
        logic advance;
        logic emit_drop;
        logic emit_miss;
        logic emit_eval;
    } ctl_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic table_empty;
        logic ptr_at_end;
        logic ref_below;
        logic last_entry;
    } dp_status_t;

    function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
        logic [COUNT_W-1:0] r;
        r = (v == {COUNT_W{1'b1}}) ? v : v + 1'b1;
        return r;
    endfunction

endpackage

/* sv/siot_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// siot_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module siot_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4096
) (
    input  logic                                       clk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* sv/siot_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// siot_datapath
// Reference table, walk pointer, running counts and result register.
// ----------------------------------------------------------------------------
module siot_datapath (
    input  logic                  clk,
    input  logic                  rst_n,
    input  siot_pkg::req_t        req,
    input  siot_pkg::ctl_cmd_t    ctl,
    output siot_pkg::dp_status_t  status,
    output siot_pkg::rsp_t        rsp,
    output logic                  rsp_valid
);

    logic [siot_pkg::CNT_W-1:0]   entry_count_reg, entry_count_next;
    logic [siot_pkg::CNT_W-1:0]   ptr_reg, ptr_next;
    logic [siot_pkg::COUNT_W-1:0] tagged_reg, tagged_next;
    logic [siot_pkg::COUNT_W-1:0] total_reg, total_next;
    logic [siot_pkg::POS_W-1:0]   q_start_reg, q_start_next;
    logic [siot_pkg::POS_W-1:0]   q_stop_reg, q_stop_next;
    siot_pkg::rsp_t               rsp_reg, rsp_next;
    logic                         rsp_valid_reg, rsp_valid_next;

    logic                         table_full;
    logic                         ram_we;
    logic [siot_pkg::ENTRY_W-1:0] ram_rdata;
    logic [siot_pkg::POS_W-1:0]   ref_start;
    logic [siot_pkg::POS_W-1:0]   ref_stop;
    logic                         hit;

    assign table_full = (entry_count_reg == siot_pkg::CNT_W'(siot_pkg::TABLE_DEPTH));
    assign ram_we     = ctl.append && !table_full;
    assign ref_start  = ram_rdata[siot_pkg::ENTRY_W-1:siot_pkg::POS_W];
    assign ref_stop   = ram_rdata[siot_pkg::POS_W-1:0];
    assign hit        = (ref_start < q_stop_reg);

    // read address follows the next pointer, so data lines up with ptr_reg
    siot_ram #(
        .WIDTH (siot_pkg::ENTRY_W),
        .DEPTH (siot_pkg::TABLE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (entry_count_reg[siot_pkg::ADDR_W-1:0]),
        .wdata ({req.start_pos, req.stop_pos}),
        .raddr (ptr_next[siot_pkg::ADDR_W-1:0]),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        entry_count_next = entry_count_reg;
        ptr_next         = ptr_reg;
        tagged_next      = tagged_reg;
        total_next       = total_reg;
        q_start_next     = q_start_reg;
        q_stop_next      = q_stop_reg;
        rsp_next         = rsp_reg;
        rsp_valid_next   = 1'b0;

        if (ctl.clear)
        begin
            entry_count_next = '0;
            ptr_next         = '0;
            tagged_next      = '0;
            total_next       = '0;
        end

        if (ram_we)
        begin
            entry_count_next = entry_count_reg + 1'b1;
        end

        if (ctl.load_query)
        begin
            q_start_next = req.start_pos;
            q_stop_next  = req.stop_pos;
        end

        if (ctl.advance)
        begin
            ptr_next = ptr_reg + 1'b1;
        end

        if (ctl.emit_miss || ctl.emit_eval)
        begin
            total_next = siot_pkg::sat_inc(total_reg);
        end

        if (ctl.emit_eval && hit)
        begin
            tagged_next = siot_pkg::sat_inc(tagged_reg);
        end

        if (ctl.emit_drop || ctl.emit_miss || ctl.emit_eval)
        begin
            rsp_valid_next        = 1'b1;
            rsp_next.overlap      = ctl.emit_eval && hit;
            rsp_next.dropped      = ctl.emit_drop;
            rsp_next.tagged_count = tagged_next;
            rsp_next.total_count  = total_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_count_reg <= '0;
            ptr_reg         <= '0;
            tagged_reg      <= '0;
            total_reg       <= '0;
            rsp_valid_reg   <= 1'b0;
        end
        else
        begin
            entry_count_reg <= entry_count_next;
            ptr_reg         <= ptr_next;
            tagged_reg      <= tagged_next;
            total_reg       <= total_next;
            rsp_valid_reg   <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_start_reg <= q_start_next;
        q_stop_reg  <= q_stop_next;
        rsp_reg     <= rsp_next;
    end

    assign status.table_empty = (entry_count_reg == '0);
    assign status.ptr_at_end  = (ptr_reg >= entry_count_reg);
    assign status.ref_below   = (ref_stop < q_start_reg);
    assign status.last_entry  = ((ptr_reg + 1'b1) >= entry_count_reg);

    assign rsp       = rsp_reg;
    assign rsp_valid = rsp_valid_reg;

endmodule

/* sv/siot_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// siot_ctrl
// Command decode and pointer walk sequencing.
// ----------------------------------------------------------------------------
module siot_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [1:0]            cmd,
    input  siot_pkg::dp_status_t  status,
    output siot_pkg::ctl_cmd_t    ctl,
    output logic                  busy
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_WALK = 1'b1;

    logic state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    case (cmd)
                        siot_pkg::CMD_CLEAR:  ctl.clear  = 1'b1;
                        siot_pkg::CMD_APPEND: ctl.append = 1'b1;
                        siot_pkg::CMD_QUERY:
                        begin
                            if (status.table_empty)
                            begin
                                ctl.emit_drop = 1'b1;
                            end
                            else if (status.ptr_at_end)
                            begin
                                ctl.emit_miss = 1'b1;
                            end
                            else
                            begin
                                ctl.load_query = 1'b1;
                                state_next     = ST_WALK;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_WALK:
            begin
                // reference under the pointer is on the RAM read port
                if (status.ref_below)
                begin
                    ctl.advance = 1'b1;
                    if (status.last_entry)
                    begin
                        ctl.emit_miss = 1'b1;
                        state_next    = ST_IDLE;
                    end
                end
                else
                begin
                    ctl.emit_eval = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg == ST_WALK);

endmodule

/* sv/sorted_interval_overlap_tagger_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_interval_overlap_tagger_unit
// Tags start-sorted query intervals that overlap a start-sorted reference set.
// ----------------------------------------------------------------------------
// A word is taken when start is high and busy is low. Clear and append give
// no result. A query gives one result, shown for exactly one cycle with
// rsp_valid high in the cycle after its decision; the receiver cannot stall
// it. A query is decided without a walk when the table is empty (dropped)
// or the walk pointer is already past the last reference; otherwise the
// pointer steps over k references, each step one read of the reference RAM,
// before the query is evaluated. When the walk steps off the last reference
// the query ends on that step as a miss. Over a sorted stream k amortizes
// toward zero. The reference RAM needs no clearing pass after reset.
// ----------------------------------------------------------------------------
module sorted_interval_overlap_tagger_unit (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  siot_pkg::req_t  req,
    output siot_pkg::rsp_t  rsp,
    output logic            rsp_valid
);

    siot_pkg::ctl_cmd_t   ctl;
    siot_pkg::dp_status_t status;

    siot_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .cmd    (req.cmd),
        .status (status),
        .ctl    (ctl),
        .busy   (busy)
    );

    siot_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .ctl       (ctl),
        .status    (status),
        .rsp       (rsp),
        .rsp_valid (rsp_valid)
    );

    // a result always lands while the walk is finished
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !busy)
    else $error("result shown while walk in progress");

    // only queries produce results
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && req.cmd != siot_pkg::CMD_QUERY) |=> !rsp_valid)
    else $error("result after non-query word");

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp.tagged_count <= rsp.total_count))
    else $error("tagged count exceeds total count");

    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.dropped) |-> !rsp.overlap)
    else $error("dropped query flagged as overlap");

endmodule

/* dv/sorted_interval_overlap_tagger_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_interval_overlap_tagger_unit_tb
// Self-checking bench for the sorted interval overlap tagger.
// A short table of hand-picked words comes first: empty table, extremes,
// unsorted input, pointer past the end, unused command and clears. Random
// sessions follow. Each session is a clear, a sorted reference load and
// sorted queries, with some noise words mixed in. Each query result is
// checked field by field against a local model of the table, walk pointer
// and counts, or against the expected result typed into its table row.
// ----------------------------------------------------------------------------
module sorted_interval_overlap_tagger_unit_tb;

    import siot_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int         QUIET_LIMIT = 20000;
    localparam int         RAND_WORDS  = 500;
    localparam int         DIR_ROWS    = 25;

    typedef struct packed {
        req_t w;
        logic pin;
        rsp_t r;
    } row_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    req_t req   = '0;
    logic busy;
    rsp_t rsp;
    logic rsp_valid;

    // typed-in expectation that rides along with the word being offered
    logic pin_en  = 1'b0;
    rsp_t pin_rsp = '0;

    // local model of the tagger
    logic [POS_W-1:0]   ref_lo [TABLE_DEPTH];
    logic [POS_W-1:0]   ref_hi [TABLE_DEPTH];
    int                 ref_fill = 0;
    int                 walk_idx = 0;
    logic [COUNT_W-1:0] hits     = '0;
    logic [COUNT_W-1:0] queries  = '0;

    rsp_t pending_tags [$];
    int   mismatches = 0;
    int   quiet      = 0;
    int   burst_left = 0;
    int   words_sent = 0;

    // cmd, start, stop, pinned, expected {overlap, dropped, tagged, total}
    row_t dir_rows [DIR_ROWS] = '{
        '{'{CMD_QUERY,  32'd0,        32'd0       }, 1'b1, '{1'b0, 1'b1, 32'd0, 32'd0}},
        '{'{CMD_QUERY,  32'hFFFFFFFF, 32'hFFFFFFFF}, 1'b1, '{1'b0, 1'b1, 32'd0, 32'd0}},
        '{'{CMD_UNUSED, 32'hFFFFFFFF, 32'hFFFFFFFF}, 1'b0, '0},
        '{'{CMD_APPEND, 32'd100,      32'd200     }, 1'b0, '0},
        '{'{CMD_APPEND, 32'd300,      32'd400     }, 1'b0, '0},
        '{'{CMD_APPEND, 32'hFFFFFFF0, 32'hFFFFFFFF}, 1'b0, '0},
        '{'{CMD_QUERY,  32'd0,        32'd0       }, 1'b1, '{1'b0, 1'b0, 32'd0, 32'd1}},
        '{'{CMD_QUERY,  32'd150,      32'd160     }, 1'b0, '0},
        '{'{CMD_QUERY,  32'd250,      32'd260     }, 1'b0, '0},
        '{'{CMD_QUERY,  32'd350,      32'hFFFFFFFF}, 1'b0, '0},
        '{'{CMD_QUERY,  32'hFFFFFFFF, 32'hFFFFFFFF}, 1'b0, '0},
        '{'{CMD_QUERY,  32'd0,        32'hFFFFFFFF}, 1'b0, '0},
        '{'{CMD_APPEND, 32'd10,       32'd20      }, 1'b0, '0},
        '{'{CMD_QUERY,  32'd5,        32'd15      }, 1'b0, '0},
        '{'{CMD_CLEAR,  32'd0,        32'd0       }, 1'b0, '0},
        '{'{CMD_QUERY,  32'd5,        32'd6       }, 1'b1, '{1'b0, 1'b1, 32'd0, 32'd0}},
        '{'{CMD_APPEND, 32'd0,        32'd0       }, 1'b0, '0},
        '{'{CMD_APPEND, 32'd10,       32'd10      }, 1'b0, '0},
        '{'{CMD_QUERY,  32'd20,       32'd30      }, 1'b1, '{1'b0, 1'b0, 32'd0, 32'd1}},
        '{'{CMD_QUERY,  32'd0,        32'd0       }, 1'b0, '0},
        '{'{CMD_APPEND, 32'd40,       32'd50      }, 1'b0, '0},
        '{'{CMD_QUERY,  32'd45,       32'd100     }, 1'b0, '0},
        '{'{CMD_UNUSED, 32'd0,        32'd0       }, 1'b0, '0},
        '{'{CMD_CLEAR,  32'hFFFFFFFF, 32'hFFFFFFFF}, 1'b0, '0},
        '{'{CMD_QUERY,  32'hAAAAAAAA, 32'h55555555}, 1'b1, '{1'b0, 1'b1, 32'd0, 32'd0}}
    };

    sorted_interval_overlap_tagger_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req       (req),
        .rsp       (rsp),
        .rsp_valid (rsp_valid)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Applies one accepted word to the local model; returns 1 when it yields a result.
    function automatic bit tag_word(input req_t w, output rsp_t r);
        bit hit;
        r   = '0;
        hit = 1'b0;
        case (w.cmd)
            CMD_CLEAR:
            begin
                ref_fill = 0;
                walk_idx = 0;
                hits     = '0;
                queries  = '0;
                return 1'b0;
            end
            CMD_APPEND:
            begin
                if (ref_fill < TABLE_DEPTH)
                begin
                    ref_lo[ref_fill] = w.start_pos;
                    ref_hi[ref_fill] = w.stop_pos;
                    ref_fill++;
                end
                return 1'b0;
            end
            CMD_QUERY:
            begin
                if (ref_fill == 0)
                begin
                    // empty table: dropped, counts untouched
                    r.dropped      = 1'b1;
                    r.tagged_count = hits;
                    r.total_count  = queries;
                    return 1'b1;
                end
                while (walk_idx < ref_fill && ref_hi[walk_idx] < w.start_pos)
                    walk_idx++;
                hit = (walk_idx < ref_fill) && (ref_lo[walk_idx] < w.stop_pos);
                if (hit && hits != '1)
                    hits++;
                if (queries != '1)
                    queries++;
                r.overlap      = hit;
                r.tagged_count = hits;
                r.total_count  = queries;
                return 1'b1;
            end
            default:
                return 1'b0;
        endcase
    endfunction

    function automatic logic [POS_W-1:0] pos_add(input logic [POS_W-1:0] a,
                                                 input int unsigned b);
        logic [POS_W:0] s;
        s = a + b;
        return s[POS_W] ? '1 : s[POS_W-1:0];
    endfunction

    task automatic report_miss(input string what, input rsp_t want, input rsp_t got);
        mismatches++;
        if (mismatches <= 10)
            $display({"%s: expected ov=%0b dr=%0b tag=%0d tot=%0d,",
                      " got ov=%0b dr=%0b tag=%0d tot=%0d"},
                     what, want.overlap, want.dropped, want.tagged_count, want.total_count,
                     got.overlap, got.dropped, got.tagged_count, got.total_count);
    endtask

    // Offers one word and returns at the edge that takes it.
    task automatic send(input req_t w, input bit pin = 1'b0, input rsp_t want = '0);
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
                                                     : $urandom_range(1, 12);
            start <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        start   <= 1'b1;
        req     <= w;
        pin_en  <= pin;
        pin_rsp <= want;
        do @(posedge clk); while (busy);
        burst_left--;
        if (w.cmd != CMD_UNUSED)
            words_sent++;
    endtask

    task automatic drain();
        start <= 1'b0;
        do @(posedge clk); while (pending_tags.size() != 0);
    endtask

    // Monitor: check results, then record the word taken at this edge.
    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n)
        begin
            if (rsp_valid)
            begin
                if (pending_tags.size() == 0)
                    report_miss("unexpected result", '0, rsp);
                else
                begin
                    want = pending_tags.pop_front();
                    if (rsp.overlap !== want.overlap || rsp.dropped !== want.dropped ||
                        rsp.tagged_count !== want.tagged_count ||
                        rsp.total_count !== want.total_count)
                        report_miss("result mismatch", want, rsp);
                end
            end
            if (start && !busy && tag_word(req, want))
            begin
                if (pin_en)
                    want = pin_rsp;
                pending_tags = {pending_tags, want};
            end
            if ((start && !busy) || rsp_valid)
                quiet = 0;
            else if (quiet >= QUIET_LIMIT)
            begin
                $display("watchdog: no progress for %0d cycles", QUIET_LIMIT);
                $display("status: fail");
                $finish;
            end
            else
                quiet++;
        end
    end

    initial
    begin
        int          n_ref;
        int          n_qry;
        int          smax;
        logic [31:0] rp;
        logic [31:0] qp;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
            send(dir_rows[i].w, dir_rows[i].pin, dir_rows[i].r);
        drain();

        // random sessions: clear, sorted load, sorted queries, some noise
        while (words_sent < DIR_ROWS + RAND_WORDS)
        begin
            n_ref = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 24);
            n_qry = $urandom_range(4, 36);
            case ($urandom_range(0, 2))
                0:       smax = 8;
                1:       smax = 1000;
                default: smax = 1 << 26;
            endcase
            rp = $urandom;
            if ($urandom_range(0, 1))
                rp = rp >> $urandom_range(1, 31);
            qp = (rp > smax) ? rp - smax : '0;
            send(req_t'{CMD_CLEAR, $urandom, $urandom});
            for (int i = 0; i < n_ref + n_qry; i++)
            begin
                if ($urandom_range(0, 11) == 0)
                    send(req_t'{2'($urandom_range(0, 3)), $urandom, $urandom});
                else if (i < n_ref)
                begin
                    rp = pos_add(rp, $urandom_range(0, smax));
                    send(req_t'{CMD_APPEND, rp, pos_add(rp, $urandom_range(0, smax))});
                end
                else
                begin
                    qp = pos_add(qp, $urandom_range(0, smax));
                    send(req_t'{CMD_QUERY, qp, pos_add(qp, $urandom_range(0, smax))});
                end
            end
            if ($urandom_range(0, 3) == 0)
                drain();
        end

        start <= 1'b0;
        do @(posedge clk); while (pending_tags.size() != 0);
        repeat (16) @(posedge clk);

        if (mismatches == 0 && pending_tags.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

/* sim.f */
sv/siot_pkg.sv
sv/siot_ram.sv
sv/siot_datapath.sv
sv/siot_ctrl.sv
sv/sorted_interval_overlap_tagger_unit.sv
dv/sorted_interval_overlap_tagger_unit_tb.sv
